// File: design/atpr_pkg.sv
// ============================================================================
// atpr_pkg: shared types and constants for the accelerometer tilt block
// Holds the CORDIC angle table, clamp thresholds and status codes.
// ============================================================================
package atpr_pkg;

   localparam int FifoDepthDefault  = 1024;
   localparam int FrameBytesDefault = 14;

   localparam int Stages   = 20;
   // Datapath widths: accel * 256 is 24 bits signed; CORDIC growth and the
   // 180 degree turn need headroom.
   localparam int XyW      = 28;
   localparam int ZW       = 26;
   localparam int InvGain  = 39797;
   localparam logic signed [ZW-1:0] Deg180 = ZW'(11796480);

   typedef enum logic [1:0] {
      STATUS_VALID     = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_NEAR_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [XyW-1:0] x;
      logic signed [XyW-1:0] y;
      logic signed [ZW-1:0]  z;
   } cordic_type;

   function automatic logic signed [ZW-1:0] atan_entry(input int i);
      logic signed [ZW-1:0] r;
      r = '0;
      unique case (i)
         0:  r = ZW'(2949120);
         1:  r = ZW'(1740967);
         2:  r = ZW'(919879);
         3:  r = ZW'(466945);
         4:  r = ZW'(234379);
         5:  r = ZW'(117304);
         6:  r = ZW'(58666);
         7:  r = ZW'(29335);
         8:  r = ZW'(14668);
         9:  r = ZW'(7334);
         10: r = ZW'(3667);
         11: r = ZW'(1833);
         12: r = ZW'(917);
         13: r = ZW'(458);
         14: r = ZW'(229);
         15: r = ZW'(115);
         16: r = ZW'(57);
         17: r = ZW'(29);
         18: r = ZW'(14);
         19: r = ZW'(7);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [12:0] clamp_entry(input logic [1:0] rng);
      logic [12:0] r;
      r = '0;
      unique case (rng)
         2'd0: r = 13'd4194;
         2'd1: r = 13'd2097;
         2'd2: r = 13'd1049;
         2'd3: r = 13'd524;
         default: r = 13'd4194;
      endcase
      return r;
   endfunction

endpackage

// File: design/atpr_cell.sv
// ============================================================================
// atpr_cell: one vectoring CORDIC micro-rotation
// Registered cell; a chain of these forms the rotator pipeline.
// ============================================================================
module atpr_cell #(
   parameter int SHIFT = 0
) (
   input  logic                  clock,
   input  logic                  enable,
   input  atpr_pkg::cordic_type  din,
   output atpr_pkg::cordic_type  dout
);
   atpr_pkg::cordic_type q_in, q_ff;
   logic signed [atpr_pkg::XyW-1:0] dx, dy;

   always_comb begin
      dx = din.y >>> SHIFT;
      dy = din.x >>> SHIFT;
      if (!din.y[atpr_pkg::XyW-1]) begin
         q_in.x = din.x + dx;
         q_in.y = din.y - dy;
         q_in.z = din.z + atpr_pkg::atan_entry(SHIFT);
      end else begin
         q_in.x = din.x - dx;
         q_in.y = din.y + dy;
         q_in.z = din.z - atpr_pkg::atan_entry(SHIFT);
      end
   end

   // The register holds its contents while the pipeline is stalled.
   always_ff @(posedge clock) begin
      if (enable) begin
         q_ff <= q_in;
      end
   end

   assign dout = q_ff;
endmodule

// File: design/atpr_chain.sv
// ============================================================================
// atpr_chain: row of CORDIC cells with a side-band delay line
// Carries a side word alongside each rotation so results stay aligned.
// ============================================================================
module atpr_chain #(
   parameter int SIDE_W = 8
) (
   input  logic                  clock,
   input  logic                  enable,
   input  atpr_pkg::cordic_type  din,
   input  logic [SIDE_W-1:0]     side_in,
   output atpr_pkg::cordic_type  dout,
   output logic [SIDE_W-1:0]     side_out
);
   atpr_pkg::cordic_type link [atpr_pkg::Stages+1];
   logic [SIDE_W-1:0] side_ff [atpr_pkg::Stages];

   assign link[0] = din;

   for (genvar g = 0; g < atpr_pkg::Stages; g++) begin : g_cell
      atpr_cell #(.SHIFT(g)) u_cell (
         .clock  (clock),
         .enable (enable),
         .din    (link[g]),
         .dout   (link[g+1])
      );
      always_ff @(posedge clock) begin
         if (enable) begin
            side_ff[g] <= (g == 0) ? side_in : side_ff[(g == 0) ? 0 : g-1];
         end
      end
   end

   assign dout     = link[atpr_pkg::Stages];
   assign side_out = side_ff[atpr_pkg::Stages-1];
endmodule

// File: design/accel_tilt_pitch_roll.sv
// ============================================================================
// accel_tilt_pitch_roll: pitch, roll and die temperature from one frame read
// Two CORDIC chains in series (roll/magnitude, then pitch) with scaling stages.
// ============================================================================
// Pipeline: a req transaction passes through 45 register stages before its rsp
// result can be accepted.
// Throughput: one transaction per cycle; the pipeline advances whenever the
// output register is free or being emptied.
// Reset: synchronous, active high; clears the valid pipeline and sets
// accel_range to 2g. Payload registers are not reset.
module accel_tilt_pitch_roll #(
   parameter int FIFO_DEPTH  = atpr_pkg::FifoDepthDefault,
   parameter int FRAME_BYTES = atpr_pkg::FrameBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   // tdata: byte_count[10:0], accel_x[26:11], accel_y[42:27], accel_z[58:43],
   //        temp_raw[74:59], zero fill to 80 bits
   input  logic [79:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: status[1:0], pitch[16:2], roll[32:17], temperature[47:33]
   output logic [47:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: accel_range[1:0]
   input  logic [1:0]  csr_tdata,
   input  logic        csr_tvalid,
   output logic        csr_tready
);
   localparam int XyW  = atpr_pkg::XyW;
   localparam int ZW   = atpr_pkg::ZW;
   localparam int Lat  = 2 * atpr_pkg::Stages + 5;
   localparam int SideW = 2 + 2 + 16 + 15 + 17 + 1 + ZW;

   // The whole pipeline moves together, stalled only when the output
   // register holds a result nobody is taking.
   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign csr_tready = 1'b1;

   logic [1:0] range_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= 2'd0;
      end else if (csr_tvalid && csr_tready) begin
         range_ff <= csr_tdata;
      end
   end

   // Valid bits of every pipeline position.
   logic [Lat-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[Lat-2:0], req_tvalid};
      end
   end
   assign rsp_tvalid = vld_ff[Lat-1];

   // Stage 0: unpack, classify, prepare the roll rotation.
   logic [10:0]        cnt;
   logic signed [15:0] ax, ay, az, tr;
   assign cnt = req_tdata[10:0];
   assign ax  = req_tdata[26:11];
   assign ay  = req_tdata[42:27];
   assign az  = req_tdata[58:43];
   assign tr  = req_tdata[74:59];

   atpr_pkg::cordic_type a0_ff;
   logic [1:0]  st0_ff;
   logic        zero0_ff;
   logic signed [15:0] ax0_ff;
   logic signed [ZW-1:0] base0_ff;
   logic signed [16:0] temp0_ff;
   logic [1:0] rng0_ff;

   logic signed [XyW-1:0] xs, ys;
   logic signed [18:0] n5;
   logic [18:0] nabs;
   logic [17:0] nbias;
   logic [35:0] qprod;
   logic [18:0] q17;
   always_comb begin
      xs = XyW'(az) <<< 8;
      ys = XyW'(ay) <<< 8;
      n5 = 19'(tr) * 19'sd5;
      nabs = n5[18] ? 19'(-n5) : n5;
      // round(|n| / 17) equals floor((|n| + 8) / 17); the division is a
      // multiplication by ceil(2^22 / 17), exact for every operand below 2^18.
      nbias = 18'(nabs + 19'd8);
      qprod = 36'(nbias) * 36'd246724;
      q17   = 19'(qprod[35:22]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (az[15]) begin
            a0_ff.x  <= -xs;
            a0_ff.y  <= -ys;
            base0_ff <= ay[15] ? -atpr_pkg::Deg180 : atpr_pkg::Deg180;
         end else begin
            a0_ff.x  <= xs;
            a0_ff.y  <= ys;
            base0_ff <= '0;
         end
         a0_ff.z  <= '0;
         zero0_ff <= (ay == 16'sd0) && (az == 16'sd0);
         ax0_ff   <= ax;
         rng0_ff  <= range_ff;
         if (32'(cnt) < FRAME_BYTES) begin
            st0_ff <= atpr_pkg::STATUS_EMPTY;
         end else if (32'(cnt) >= FIFO_DEPTH - FRAME_BYTES) begin
            st0_ff <= atpr_pkg::STATUS_NEAR_FULL;
         end else begin
            st0_ff <= atpr_pkg::STATUS_VALID;
         end
         temp0_ff <= 17'sd3653 + (n5[18] ? -17'(q17) : 17'(q17));
      end
   end

   // Side band: status, range, ax(16), temp(15 from 17), roll later, zero, base.
   logic [SideW-1:0] s1_in, s1_out;
   assign s1_in = {st0_ff, rng0_ff, ax0_ff, temp0_ff[14:0], 17'd0, zero0_ff, base0_ff};

   atpr_pkg::cordic_type r1;
   atpr_chain #(.SIDE_W(SideW)) u_roll (
      .clock(clock), .enable(advance), .din(a0_ff), .side_in(s1_in), .dout(r1),
      .side_out(s1_out));

   // Gain correction of the magnitude and roll scaling.
   logic signed [ZW-1:0] base1;
   logic zero1;
   assign base1 = s1_out[ZW-1:0];
   assign zero1 = s1_out[ZW];

   logic [XyW-1:0] mag1_ff;
   logic signed [ZW:0] rz1_ff;
   logic [SideW-1:0] s2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         mag1_ff <= zero1 ? '0 : r1.x;
         rz1_ff  <= (ZW+1)'(base1) + (ZW+1)'(r1.z);
         s2_ff   <= s1_out;
      end
   end

   logic [XyW+16-1:0] prod2_ff;
   logic signed [ZW:0] rz2_ff;
   logic [SideW-1:0] s3_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         prod2_ff <= (XyW+16)'(mag1_ff) * (XyW+16)'(atpr_pkg::InvGain);
         rz2_ff   <= rz1_ff;
         s3_ff    <= s2_ff;
      end
   end

   // Roll hundredths and clamp of h; start of pitch rotation.
   function automatic logic signed [16:0] to_hund(input logic signed [ZW:0] z,
                                                  input logic [16:0] lim);
      logic [ZW:0] m;
      logic [ZW+7:0] h;
      logic [16:0] hs;
      m  = z[ZW] ? (ZW+1)'(-z) : z;
      h  = ((ZW+8)'(m) * (ZW+8)'(100) + (ZW+8)'(32768)) >> 16;
      hs = (h > (ZW+8)'(lim)) ? lim : 17'(h);
      return z[ZW] ? -17'(hs) : 17'(hs);
   endfunction

   atpr_pkg::cordic_type p0_ff;
   logic [SideW-1:0] s4_ff;
   logic [XyW-1:0] horiz;
   logic [12:0] clampv;
   logic signed [16:0] roll3;
   always_comb begin
      horiz  = prod2_ff[XyW+16-1:16];
      clampv = atpr_pkg::clamp_entry(s3_ff[SideW-3 -: 2]);
      roll3  = s3_ff[ZW] ? 17'sd0 : to_hund(rz2_ff, 17'd18000);
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         p0_ff.x <= (horiz < XyW'(clampv)) ? XyW'(clampv) : horiz;
         p0_ff.y <= -(XyW'($signed(s3_ff[SideW-5 -: 16])) <<< 8);
         p0_ff.z <= '0;
         s4_ff   <= {s3_ff[SideW-1 -: 2+2+16+15], roll3, s3_ff[ZW:0]};
      end
   end

   atpr_pkg::cordic_type p1;
   logic [SideW-1:0] s5;
   atpr_chain #(.SIDE_W(SideW)) u_pitch (
      .clock(clock), .enable(advance), .din(p0_ff), .side_in(s4_ff), .dout(p1),
      .side_out(s5));

   // Output register; holds while the result waits.
   logic signed [16:0] pitch5;
   logic [47:0] out_ff;
   assign pitch5 = to_hund((ZW+1)'(p1.z), 17'd9000);
   always_ff @(posedge clock) begin
      if (advance) begin
         if (s5[SideW-1 -: 2] == atpr_pkg::STATUS_VALID) begin
            out_ff <= {s5[SideW-21 -: 15], s5[ZW+16 -: 16], pitch5[14:0],
                       s5[SideW-1 -: 2]};
         end else begin
            out_ff <= {46'd0, s5[SideW-1 -: 2]};
         end
      end
   end
   assign rsp_tdata = out_ff;

   // Every register of the data path and side band shares the advance enable,
   // so a stall at the output freezes the whole pipeline in step with vld_ff.

   // A waiting result stays put until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata));

   // Only the three defined status codes are ever presented.
   a_rsp_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == atpr_pkg::STATUS_VALID) ||
                     (rsp_tdata[1:0] == atpr_pkg::STATUS_EMPTY) ||
                     (rsp_tdata[1:0] == atpr_pkg::STATUS_NEAR_FULL));

   // A frame without valid angles carries zeros in every other field.
   a_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != atpr_pkg::STATUS_VALID) |->
         rsp_tdata[47:2] == '0);
endmodule
